/* design/tscf_pkg.sv */
// Shared types and constants of the text stream filter.
// Used by tscf_front, tscf_queue users, tscf_back and text_stream_cat_filter.
// No dependencies.
package tscf_pkg;

    localparam int DEFAULT_NUMBER_DIGITS = 6;
    localparam int QUEUE_DEPTH           = 4;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    // Register indexes, byte address divided by four.
    localparam logic [2:0] REG_NUMBER_NONBLANK  = 3'd0;
    localparam logic [2:0] REG_NUMBER_ALL       = 3'd1;
    localparam logic [2:0] REG_SQUEEZE_BLANK    = 3'd2;
    localparam logic [2:0] REG_SHOW_ENDS        = 3'd3;
    localparam logic [2:0] REG_SHOW_TABS        = 3'd4;
    localparam logic [2:0] REG_SHOW_NONPRINTING = 3'd5;

    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_NL     = 8'h0A;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_MINUS  = 8'h2D;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_QUEST  = 8'h3F;
    localparam logic [7:0] CHAR_UPPER_I = 8'h49;
    localparam logic [7:0] CHAR_UPPER_M = 8'h4D;
    localparam logic [7:0] CHAR_CARET  = 8'h5E;
    localparam logic [7:0] CHAR_DEL    = 8'h7F;
    localparam logic [7:0] CTRL_LIMIT  = 8'h20;
    localparam logic [7:0] HIGH_LOW    = 8'h80;
    localparam logic [7:0] HIGH_LIMIT  = 8'hA0;
    localparam logic [7:0] CARET_OFFSET = 8'h40;

    typedef struct packed {
        logic number_nonblank;
        logic number_all;
        logic squeeze_blank;
        logic show_ends;
        logic show_tabs;
        logic show_nonprinting;
    } cfg_t;

    // One queued job: an optional prefix (digits or padding, then a tab)
    // followed by one to four body bytes, body[0] first.
    typedef struct packed {
        logic            has_prefix;
        logic [1:0]      body_last;
        logic [3:0][7:0] body;
    } body_t;

endpackage

/* design/tscf_queue.sv */
// Small first-in first-out queue between the front and back ends.
// Register-based storage; DEPTH must be a power of two.
// No package dependencies.
module tscf_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = CNT_W'(count_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* design/tscf_front.sv */
// Front end: accepts input words, keeps the line state and the BCD line
// counter, and turns each kept byte into one queued job.
// Depends on tscf_pkg.
module tscf_front #(
    parameter int NUMBER_DIGITS = tscf_pkg::DEFAULT_NUMBER_DIGITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  tscf_pkg::cfg_t                 cfg,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // data_byte
    input  logic                           s_tuser,   // start_of_file
    input  logic                           q_full,
    output logic                           q_push,
    output tscf_pkg::body_t                q_body,
    output logic [NUMBER_DIGITS-1:0][7:0]  q_prefix
);

    localparam int CNT_W = 4 * NUMBER_DIGITS;
    localparam logic [CNT_W-1:0] COUNT_ONE = CNT_W'(1);

    logic [7:0]                    prev_reg, prev_next;
    logic                          blank_reg, blank_next;
    logic [NUMBER_DIGITS-1:0][3:0] count_reg, count_next;

    logic [7:0]                    ch;
    logic [7:0]                    eff_prev;
    logic                          eff_blank;
    logic [NUMBER_DIGITS-1:0][3:0] eff_count;
    logic [NUMBER_DIGITS-1:0][3:0] inc_count;
    logic [3:0]                    digit;
    logic                          seen, carry;
    logic                          is_nl, prev_nl, drop, accept;
    logic                          do_number, do_pad;
    logic [NUMBER_DIGITS-1:0][7:0] number_chars;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;

    always_comb
    begin
        ch        = s_tdata;
        eff_prev  = s_tuser ? tscf_pkg::CHAR_NL : prev_reg;
        eff_blank = s_tuser ? 1'b0 : blank_reg;
        eff_count = s_tuser ? COUNT_ONE : count_reg;

        is_nl   = (ch == tscf_pkg::CHAR_NL);
        prev_nl = (eff_prev == tscf_pkg::CHAR_NL);
        drop    = cfg.squeeze_blank && is_nl && prev_nl && eff_blank;

        do_number = prev_nl && ((cfg.number_all && !cfg.number_nonblank)
                                || (cfg.number_nonblank && !is_nl));
        do_pad    = cfg.number_nonblank && cfg.show_ends && prev_nl && is_nl;

        // Digits from the most significant down; leading zeros become spaces.
        seen = 1'b0;
        for (int i = NUMBER_DIGITS - 1; i >= 0; i--)
        begin
            digit = (eff_count[i] > 4'd9) ? 4'd9 : eff_count[i];
            seen  = seen || (digit != 4'd0) || (i == 0);
            number_chars[NUMBER_DIGITS-1-i] = seen ? (tscf_pkg::CHAR_ZERO | {4'd0, digit})
                                                   : tscf_pkg::CHAR_SPACE;
        end

        // BCD increment that holds once every digit is nine.
        carry = 1'b1;
        for (int i = 0; i < NUMBER_DIGITS; i++)
        begin
            if (carry)
            begin
                inc_count[i] = (eff_count[i] == 4'd9) ? 4'd0 : 4'(eff_count[i] + 4'd1);
            end
            else
            begin
                inc_count[i] = eff_count[i];
            end
            carry = carry && (eff_count[i] == 4'd9);
        end

        for (int i = 0; i < NUMBER_DIGITS; i++)
        begin
            q_prefix[i] = do_number ? number_chars[i] : tscf_pkg::CHAR_SPACE;
        end

        q_body.has_prefix = do_number || do_pad;
        q_body.body       = '0;
        q_body.body_last  = 2'd0;
        if (is_nl)
        begin
            if (cfg.show_ends)
            begin
                q_body.body[0]   = tscf_pkg::CHAR_DOLLAR;
                q_body.body[1]   = tscf_pkg::CHAR_NL;
                q_body.body_last = 2'd1;
            end
            else
            begin
                q_body.body[0] = tscf_pkg::CHAR_NL;
            end
        end
        else if (ch == tscf_pkg::CHAR_TAB && cfg.show_tabs)
        begin
            q_body.body[0]   = tscf_pkg::CHAR_CARET;
            q_body.body[1]   = tscf_pkg::CHAR_UPPER_I;
            q_body.body_last = 2'd1;
        end
        else if (cfg.show_nonprinting
                 && ((ch < tscf_pkg::CTRL_LIMIT && ch != tscf_pkg::CHAR_TAB)
                     || ch == tscf_pkg::CHAR_DEL))
        begin
            q_body.body[0]   = tscf_pkg::CHAR_CARET;
            q_body.body[1]   = (ch == tscf_pkg::CHAR_DEL) ? tscf_pkg::CHAR_QUEST
                                                          : 8'(ch + tscf_pkg::CARET_OFFSET);
            q_body.body_last = 2'd1;
        end
        else if (cfg.show_nonprinting && ch >= tscf_pkg::HIGH_LOW && ch < tscf_pkg::HIGH_LIMIT)
        begin
            q_body.body[0]   = tscf_pkg::CHAR_UPPER_M;
            q_body.body[1]   = tscf_pkg::CHAR_MINUS;
            q_body.body[2]   = tscf_pkg::CHAR_CARET;
            q_body.body[3]   = 8'(ch - tscf_pkg::CARET_OFFSET);
            q_body.body_last = 2'd3;
        end
        else
        begin
            q_body.body[0] = ch;
        end

        q_push = accept && !drop;

        prev_next  = prev_reg;
        blank_next = blank_reg;
        count_next = count_reg;
        if (accept)
        begin
            prev_next  = ch;
            blank_next = drop ? eff_blank : (cfg.squeeze_blank && is_nl && prev_nl);
            count_next = (do_number && !drop && !carry) ? inc_count : eff_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= tscf_pkg::CHAR_NL;
            blank_reg <= 1'b0;
            count_reg <= COUNT_ONE;
        end
        else
        begin
            prev_reg  <= prev_next;
            blank_reg <= blank_next;
            count_reg <= count_next;
        end
    end

endmodule

/* design/tscf_back.sv */
// Back end: walks the job at the head of the queue into a registered
// master-side stream, one output byte per cycle while m_tready allows it,
// and pops the job on its last byte. Depends on tscf_pkg.
module tscf_back #(
    parameter int NUMBER_DIGITS = tscf_pkg::DEFAULT_NUMBER_DIGITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    input  tscf_pkg::body_t               q_body,
    input  logic [NUMBER_DIGITS-1:0][7:0] q_prefix,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,  // out_byte
    output logic                          m_tlast
);

    localparam int SEQ_LEN = NUMBER_DIGITS + 5;
    localparam int POS_W   = $clog2(SEQ_LEN);
    localparam logic [POS_W-1:0] BODY_POS = POS_W'(NUMBER_DIGITS + 1);

    logic [7:0]       seq [SEQ_LEN];
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             started_reg, started_next;
    logic             valid_reg, valid_next;
    logic [7:0]       data_reg, data_next;
    logic             last_reg, last_next;
    logic [POS_W-1:0] pos;
    logic             step, final_byte;

    always_comb
    begin
        for (int k = 0; k < NUMBER_DIGITS; k++)
        begin
            seq[k] = q_prefix[k];
        end
        seq[NUMBER_DIGITS] = tscf_pkg::CHAR_TAB;
        for (int k = 0; k < 4; k++)
        begin
            seq[NUMBER_DIGITS+1+k] = q_body.body[k];
        end

        if (started_reg)
        begin
            pos = pos_reg;
        end
        else
        begin
            pos = q_body.has_prefix ? '0 : BODY_POS;
        end
        final_byte = (pos == POS_W'(BODY_POS + POS_W'(q_body.body_last)));

        step  = !q_empty && (!valid_reg || m_tready);
        q_pop = step && final_byte;

        valid_next   = valid_reg;
        data_next    = data_reg;
        last_next    = last_reg;
        pos_next     = pos_reg;
        started_next = started_reg;
        if (step)
        begin
            valid_next   = 1'b1;
            data_next    = seq[pos];
            last_next    = final_byte;
            started_next = !final_byte;
            pos_next     = POS_W'(pos + 1'b1);
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            started_reg <= 1'b0;
            pos_reg     <= '0;
        end
        else
        begin
            valid_reg   <= valid_next;
            started_reg <= started_next;
            pos_reg     <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

/* design/text_stream_cat_filter.sv */
// Top level of the text stream filter: configuration registers, front end,
// job queue and back end. Depends on tscf_pkg, tscf_front, tscf_queue, tscf_back.
//
// Line filter in the manner of cat with numbering, squeezing and caret
// escapes. One text byte enters per word on the slave side, with tuser
// marking the start of a file; the master side sends one output byte per
// word, with tlast on the final byte caused by an input byte. The back end
// sends one byte per cycle while the master side is ready; an input byte
// gives one output byte for most text, two for caret forms, four for high
// control bytes, and NUMBER_DIGITS+1 more for a line number or blank padding
// in front. A dropped empty line gives no output. The front end accepts a
// byte every cycle while the four-entry job queue has room; a job is held in
// the queue, then in the output register. The user must write configuration
// over the APB port only while the stream is idle; it is not enforced.
module text_stream_cat_filter #(
    parameter int NUMBER_DIGITS = tscf_pkg::DEFAULT_NUMBER_DIGITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tscf_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [tscf_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [tscf_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,  // data_byte
    input  logic                            s_tuser,  // start_of_file
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,  // out_byte
    output logic                            m_tlast   // last
);

    localparam int Q_WIDTH = $bits(tscf_pkg::body_t) + 8 * NUMBER_DIGITS;

    tscf_pkg::cfg_t cfg_reg, cfg_next;
    logic           cfg_write;
    logic [2:0]     reg_index;
    logic           read_bit;

    logic                          q_push, q_full, q_pop, q_empty;
    tscf_pkg::body_t               front_body, head_body;
    logic [NUMBER_DIGITS-1:0][7:0] front_prefix, head_prefix;
    logic [Q_WIDTH-1:0]            q_in, q_out;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        read_bit = 1'b0;
        case (reg_index)
            tscf_pkg::REG_NUMBER_NONBLANK:
            begin
                read_bit = cfg_reg.number_nonblank;
                if (cfg_write)
                begin
                    cfg_next.number_nonblank = pwdata[0];
                end
            end
            tscf_pkg::REG_NUMBER_ALL:
            begin
                read_bit = cfg_reg.number_all;
                if (cfg_write)
                begin
                    cfg_next.number_all = pwdata[0];
                end
            end
            tscf_pkg::REG_SQUEEZE_BLANK:
            begin
                read_bit = cfg_reg.squeeze_blank;
                if (cfg_write)
                begin
                    cfg_next.squeeze_blank = pwdata[0];
                end
            end
            tscf_pkg::REG_SHOW_ENDS:
            begin
                read_bit = cfg_reg.show_ends;
                if (cfg_write)
                begin
                    cfg_next.show_ends = pwdata[0];
                end
            end
            tscf_pkg::REG_SHOW_TABS:
            begin
                read_bit = cfg_reg.show_tabs;
                if (cfg_write)
                begin
                    cfg_next.show_tabs = pwdata[0];
                end
            end
            tscf_pkg::REG_SHOW_NONPRINTING:
            begin
                read_bit = cfg_reg.show_nonprinting;
                if (cfg_write)
                begin
                    cfg_next.show_nonprinting = pwdata[0];
                end
            end
            default:
            begin
                read_bit = 1'b0;
            end
        endcase
    end

    assign prdata = {{(tscf_pkg::CFG_DATA_W-1){1'b0}}, read_bit};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tscf_front #(
        .NUMBER_DIGITS (NUMBER_DIGITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_body   (front_body),
        .q_prefix (front_prefix)
    );

    assign q_in = {front_prefix, front_body};

    tscf_queue #(
        .WIDTH (Q_WIDTH),
        .DEPTH (tscf_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    assign {head_prefix, head_body} = q_out;

    tscf_back #(
        .NUMBER_DIGITS (NUMBER_DIGITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_body   (head_body),
        .q_prefix (head_prefix),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
